>>> design/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/ahef_pkg.sv
package ahef_pkg;

    localparam int RateW = 18;

    localparam logic [RateW-1:0] RATE_RESET_HZ = 18'd12000;
    localparam logic [RateW-1:0] RATE_HIGH_HZ  = 18'd12000;
    localparam logic [RateW-1:0] RATE_MID_HZ   = 18'd8000;

    localparam logic [1:0] LP_SHIFT_HIGH  = 2'd3;
    localparam logic [1:0] LP_SHIFT_MID   = 2'd2;
    localparam logic [1:0] LP_SHIFT_LOW   = 2'd1;
    localparam logic [2:0] ENV_SHIFT_HIGH = 3'd7;
    localparam logic [2:0] ENV_SHIFT_MID  = 3'd6;
    localparam logic [2:0] ENV_SHIFT_LOW  = 3'd5;

    localparam logic [7:0] ENV_MAX = 8'd128;

    typedef struct packed {
        logic [7:0] sample;
        logic       clear_state;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] filtered_sample;
        logic [7:0] envelope_level;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] lp_shift;
        logic [2:0] env_shift;
    } t_shifts;

endpackage

>>> design/ahef_shift_sel.sv
module ahef_shift_sel (
    input  logic [ahef_pkg::RateW-1:0] i_sample_rate,
    output ahef_pkg::t_shifts          o_shifts
);

    always_comb begin
        if (i_sample_rate >= ahef_pkg::RATE_HIGH_HZ) begin
            o_shifts.lp_shift  = ahef_pkg::LP_SHIFT_HIGH;
            o_shifts.env_shift = ahef_pkg::ENV_SHIFT_HIGH;
        end else if (i_sample_rate >= ahef_pkg::RATE_MID_HZ) begin
            o_shifts.lp_shift  = ahef_pkg::LP_SHIFT_MID;
            o_shifts.env_shift = ahef_pkg::ENV_SHIFT_MID;
        end else begin
            o_shifts.lp_shift  = ahef_pkg::LP_SHIFT_LOW;
            o_shifts.env_shift = ahef_pkg::ENV_SHIFT_LOW;
        end
    end

endmodule

>>> design/ahef_calc.sv
module ahef_calc (
    input  ahef_pkg::t_in_beat   i_beat,
    input  ahef_pkg::t_shifts    i_shifts,
    input  logic signed [7:0]    i_lp_acc,
    input  logic [7:0]           i_env_acc,
    output logic signed [7:0]    o_lp_acc_next,
    output logic [7:0]           o_env_acc_next,
    output ahef_pkg::t_out_beat  o_beat
);

    logic signed [7:0] x;
    logic signed [7:0] lp_cur;
    logic [7:0]        env_cur;
    logic signed [9:0] lp_diff;
    logic signed [9:0] lp_step;
    logic signed [9:0] lp_sum;
    logic signed [7:0] lp_new;
    logic signed [9:0] hp;
    logic [8:0]        mag;
    logic signed [9:0] env_diff;
    logic signed [9:0] env_step;
    logic signed [9:0] env_sum;
    logic [7:0]        env_new;
    logic [6:0]        env_lvl;

    // recenter: sample - 128 is the sample with its top bit flipped
    assign x       = $signed({~i_beat.sample[7], i_beat.sample[6:0]});
    assign lp_cur  = i_beat.clear_state ? 8'sd0 : i_lp_acc;
    assign env_cur = i_beat.clear_state ? 8'd0 : i_env_acc;

    assign lp_diff = $signed({{2{x[7]}}, x}) - $signed({{2{lp_cur[7]}}, lp_cur});
    assign lp_step = lp_diff >>> i_shifts.lp_shift;
    assign lp_sum  = $signed({{2{lp_cur[7]}}, lp_cur}) + lp_step;
    assign lp_new  = lp_sum[7:0];

    assign hp = $signed({{2{x[7]}}, x}) - $signed({{2{lp_new[7]}}, lp_new}) + 10'sd128;

    // magnitude of the new low-pass value, 0..128
    assign mag = lp_new[7] ? (9'd0 - {1'b1, lp_new}) : {1'b0, lp_new};

    assign env_diff = $signed({1'b0, mag}) - $signed({2'b00, env_cur});
    assign env_step = env_diff >>> i_shifts.env_shift;
    assign env_sum  = $signed({2'b00, env_cur}) + env_step;

    always_comb begin
        if (env_sum < 10'sd0) begin
            env_new = 8'd0;
        end else begin
            env_new = env_sum[7:0];
        end
        env_lvl = (env_new > 8'd127) ? 7'd127 : env_new[6:0];

        if (hp < 10'sd0) begin
            o_beat.filtered_sample = 8'd0;
        end else if (hp > 10'sd255) begin
            o_beat.filtered_sample = 8'd255;
        end else begin
            o_beat.filtered_sample = hp[7:0];
        end
        o_beat.envelope_level = {env_lvl, 1'b0};
    end

    assign o_lp_acc_next  = lp_new;
    assign o_env_acc_next = env_new;

endmodule

>>> design/audio_highpass_envelope_follower.sv
// A beat accepted into the input register moves to the output register, where
// its result is offered, once the output stage can advance.
// Throughput: one sample per cycle while i_out_stall allows; the filter state
// loop is combinational adds and shifts from input to result/state registers.
// Reset (synchronous, active low): empties both stages, clears both filter
// accumulators and sets the sample rate register to 12000 Hz.
`include "assert_macros.svh"

module audio_highpass_envelope_follower (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ahef_pkg::RateW-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ahef_pkg::t_in_beat          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ahef_pkg::t_out_beat         o_out_data
);

    logic [ahef_pkg::RateW-1:0] r_sample_rate;
    logic                       r_in_valid;
    ahef_pkg::t_in_beat         r_in_beat;
    logic                       r_out_valid;
    ahef_pkg::t_out_beat        r_out_beat;
    logic signed [7:0]          r_lp_acc;
    logic [7:0]                 r_env_acc;

    logic                       n_in_valid;
    logic signed [7:0]          n_lp_acc;
    logic [7:0]                 n_env_acc;
    ahef_pkg::t_out_beat        n_out_beat;
    ahef_pkg::t_shifts          shifts;
    logic                       advance;
    logic                       load;
    logic                       commit;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;
    assign commit     = r_in_valid && advance;

    always_comb begin
        if (load) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    ahef_shift_sel u_shift_sel (
        .i_sample_rate (r_sample_rate),
        .o_shifts      (shifts)
    );

    ahef_calc u_calc (
        .i_beat         (r_in_beat),
        .i_shifts       (shifts),
        .i_lp_acc       (r_lp_acc),
        .i_env_acc      (r_env_acc),
        .o_lp_acc_next  (n_lp_acc),
        .o_env_acc_next (n_env_acc),
        .o_beat         (n_out_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= ahef_pkg::RATE_RESET_HZ;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_lp_acc      <= 8'sd0;
            r_env_acc     <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_sample_rate <= i_cfg_wdata;
            end
            r_in_valid <= n_in_valid;
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            // commit filter state only when the beat moves to the output
            if (commit) begin
                r_lp_acc  <= n_lp_acc;
                r_env_acc <= n_env_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_beat <= i_in_data;
        end
        if (commit) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    `ASSERT_SAME(a_stall_needs_beat, i_clk, i_rst_n, o_in_stall, r_in_valid)
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, commit, r_out_valid)
    `ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !commit, $stable(r_lp_acc) && $stable(r_env_acc))
    `ASSERT_SAME(a_env_bound, i_clk, i_rst_n, 1'b1, r_env_acc <= ahef_pkg::ENV_MAX)

endmodule
